[rtl/core/smlb_pkg.sv]
// Shared constants and types for the stepper move, limit and backoff core.
package smlb_pkg;

  localparam int STEPS_PER_MM       = 4000;
  localparam int BACKOFF_MM         = 3;
  localparam int SETTLE_TICKS       = 10;
  localparam int BACKOFF_HALF_TICKS = 32;

  localparam int STEPS_W = 24;
  localparam int TIMER_W = 16;
  localparam int DIST_W  = 12;

  localparam logic [STEPS_W-1:0] BACKOFF_STEPS  = STEPS_W'(BACKOFF_MM * STEPS_PER_MM);
  localparam logic [TIMER_W-1:0] SETTLE_LEN     = TIMER_W'(SETTLE_TICKS);
  localparam logic [TIMER_W-1:0] BACKOFF_HALF   = TIMER_W'(BACKOFF_HALF_TICKS);
  localparam logic [TIMER_W-1:0] HALF_PERIOD_RST = 16'd125;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               start;
    logic               homing;
    logic               dir;
    logic [STEPS_W-1:0] steps;
    logic               hit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/smlb_if.sv]
// Channel interfaces for command beats, result beats and configuration writes.
interface smlb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       direction;
  logic [7:0] tens_mm;
  logic [7:0] units_mm;
  logic       limit_hit;

  modport source (output valid, output operation, output direction, output tens_mm,
                  output units_mm, output limit_hit, input ready);
  modport sink   (input valid, input operation, input direction, input tens_mm,
                  input units_mm, input limit_hit, output ready);
endinterface

interface smlb_res_if;
  logic valid;
  logic ready;
  logic step_level;
  logic dir_level;
  logic enable_n;
  logic busy_res;
  logic limit_flag;

  modport source (output valid, output step_level, output dir_level, output enable_n,
                  output busy_res, output limit_flag, input ready);
  modport sink   (input valid, input step_level, input dir_level, input enable_n,
                  input busy_res, input limit_flag, output ready);
endinterface

interface smlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/smlb_front.sv]
// Front end: accepts command beats, decodes the operation and works out the step count.
module smlb_front
  import smlb_pkg::*;
(
  smlb_cmd_if.sink      cmd,
  input  queue_status_t qstat,
  output logic          push,
  output cmd_t          push_cmd
);

  logic [DIST_W-1:0]  dist_mm;
  logic [STEPS_W-1:0] move_steps;

  assign dist_mm    = DIST_W'({4'd0, cmd.tens_mm} * 12'd10) + DIST_W'(cmd.units_mm);
  assign move_steps = STEPS_W'({12'd0, dist_mm} * STEPS_W'(STEPS_PER_MM));

  assign cmd.ready = !qstat.full;
  assign push      = cmd.valid && !qstat.full;

  always_comb begin
    push_cmd.dir   = cmd.direction;
    push_cmd.hit   = cmd.limit_hit;
    unique case (cmd.operation)
      OP_MOVE: begin
        push_cmd.start  = 1'b1;
        push_cmd.homing = 1'b0;
        push_cmd.steps  = move_steps;
      end
      OP_HOME: begin
        push_cmd.start  = 1'b1;
        push_cmd.homing = 1'b1;
        push_cmd.steps  = '0;
      end
      default: begin
        push_cmd.start  = 1'b0;
        push_cmd.homing = 1'b0;
        push_cmd.steps  = '0;
      end
    endcase
  end

endmodule

[rtl/core/smlb_queue.sv]
// Short command queue between the front end and the motion engine.
module smlb_queue
  import smlb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t qstat
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/smlb_back.sv]
// Motion engine: runs settle, stepping and backoff one tick per beat and registers the result.
module smlb_back
  import smlb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  smlb_cfg_if.sink      cfg,
  input  cmd_t          head,
  input  queue_status_t qstat,
  output logic          pop,
  smlb_res_if.source    res
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_SETTLE     = 3'd1;
  localparam logic [2:0] PH_STEP       = 3'd2;
  localparam logic [2:0] PH_REV_SETTLE = 3'd3;
  localparam logic [2:0] PH_BACKOFF    = 3'd4;

  logic [TIMER_W-1:0] half_period;
  logic [2:0]         phase, phase_next;
  logic [STEPS_W-1:0] steps_left, steps_left_next;
  logic [TIMER_W-1:0] half_timer, half_timer_next;
  logic               pulse_high, pulse_high_next;
  logic               dir_reg, dir_reg_next;
  logic               homing_mode, homing_mode_next;
  logic               limit_latch, limit_latch_next;
  logic               driver_off, driver_off_next;
  logic [TIMER_W-1:0] len;
  logic [TIMER_W-1:0] settle_dec;
  logic               backoff;

  assign cfg.ready = 1'b1;
  assign pop       = !qstat.empty && (!res.valid || res.ready);

  assign backoff    = (phase == PH_BACKOFF);
  assign len        = backoff ? BACKOFF_HALF :
                      ((half_period == '0) ? TIMER_W'(1) : half_period);
  assign settle_dec = (half_timer != '0) ? half_timer - 1'b1 : half_timer;

  always_comb begin
    phase_next       = phase;
    steps_left_next  = steps_left;
    half_timer_next  = half_timer;
    pulse_high_next  = pulse_high;
    dir_reg_next     = dir_reg;
    homing_mode_next = homing_mode;
    limit_latch_next = limit_latch | head.hit;
    driver_off_next  = driver_off;
    unique case (phase)
      PH_IDLE: begin
        if (head.start) begin
          driver_off_next  = 1'b0;
          dir_reg_next     = head.dir;
          homing_mode_next = head.homing;
          steps_left_next  = head.steps;
          phase_next       = PH_SETTLE;
          half_timer_next  = SETTLE_LEN;
          pulse_high_next  = 1'b0;
        end
      end
      PH_SETTLE, PH_REV_SETTLE: begin
        half_timer_next = settle_dec;
        if (settle_dec == '0) begin
          phase_next = (phase == PH_SETTLE) ? PH_STEP : PH_BACKOFF;
        end
      end
      PH_STEP, PH_BACKOFF: begin
        if (half_timer != '0) begin
          half_timer_next = half_timer - 1'b1;
        end else if (pulse_high) begin
          pulse_high_next = 1'b0;
          half_timer_next = len - 1'b1;
        end else if (!backoff) begin
          if (limit_latch_next) begin
            dir_reg_next    = !dir_reg;
            steps_left_next = BACKOFF_STEPS;
            phase_next      = PH_REV_SETTLE;
            half_timer_next = SETTLE_LEN;
            pulse_high_next = 1'b0;
          end else if (!homing_mode && steps_left == '0) begin
            phase_next = PH_IDLE;
          end else begin
            if (!homing_mode) begin
              steps_left_next = steps_left - 1'b1;
            end
            pulse_high_next = 1'b1;
            half_timer_next = len - 1'b1;
          end
        end else begin
          if (steps_left == '0) begin
            limit_latch_next = 1'b0;
            if (homing_mode) begin
              driver_off_next = 1'b1;
            end
            phase_next = PH_IDLE;
          end else begin
            steps_left_next = steps_left - 1'b1;
            pulse_high_next = 1'b1;
            half_timer_next = len - 1'b1;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        pulse_high_next = 1'b0;
        half_timer_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
    end else if (cfg.valid) begin
      half_period <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      steps_left  <= '0;
      half_timer  <= '0;
      pulse_high  <= 1'b0;
      dir_reg     <= 1'b0;
      homing_mode <= 1'b0;
      limit_latch <= 1'b0;
      driver_off  <= 1'b1;
    end else if (pop) begin
      phase       <= phase_next;
      steps_left  <= steps_left_next;
      half_timer  <= half_timer_next;
      pulse_high  <= pulse_high_next;
      dir_reg     <= dir_reg_next;
      homing_mode <= homing_mode_next;
      limit_latch <= limit_latch_next;
      driver_off  <= driver_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.step_level <= pulse_high_next;
      res.dir_level  <= dir_reg_next;
      res.enable_n   <= driver_off_next;
      res.busy_res   <= (phase_next != PH_IDLE);
      res.limit_flag <= limit_latch_next;
    end
  end

endmodule

[rtl/core/stepper_move_limit_backoff_core.sv]
// Top level of the stepper pulse generator with limit backoff and homing.
// Every command beat is one tick and yields exactly one result beat, the output levels after
// that tick. The core takes one beat per clock cycle while the queue is not full; an accepted
// command beat is written into the queue, and its result then into the result register. The front
// end decodes the command and forms the step count with two constant multiplies, a four-entry
// queue holds decoded beats, and the motion engine advances its phase, timer and step counter
// once per beat into a result register. A stalled result side fills the queue, after which
// command ready drops. A move or home command acts only while the motion engine is idle and
// is otherwise a plain tick; the half period register is written through the configuration
// channel, and the user must write it only while the core is idle; the block does not enforce it.
module stepper_move_limit_backoff_core
  import smlb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  smlb_cmd_if.sink   cmd,
  smlb_cfg_if.sink   cfg,
  smlb_res_if.source res
);

  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t qstat;

  smlb_front u_front (
    .cmd      (cmd),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  smlb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  smlb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .res   (res)
  );

endmodule

[tb/sv/stepper_move_limit_backoff_core_test.sv]
// Self-checking testbench for the stepper move, limit and backoff core.
module stepper_move_limit_backoff_core_test;
  import smlb_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RUN_LIMIT = 4_000_000;

  typedef enum logic [2:0] {
    MP_IDLE, MP_SETTLE, MP_STEP, MP_REV_SETTLE, MP_BACKOFF
  } motion_phase_t;

  typedef struct packed {
    logic step;
    logic dir;
    logic enable_n;
    logic busy;
    logic flag;
  } motor_levels_t;

  typedef struct packed {
    logic [1:0]    op;
    logic          dir;
    logic [7:0]    tens;
    logic [7:0]    units;
    logic          hit;
    logic          typed;
    motor_levels_t want;
  } tick_row_t;

  // Levels are {step, dir, enable_n, busy, flag}.
  tick_row_t opening_rows [14] = '{
    '{OP_TICK,  1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 5'b00100},
    '{OP_SPARE, 1'b1, 8'd255, 8'd255, 1'b0, 1'b1, 5'b00100},
    '{OP_MOVE,  1'b1, 8'd0,   8'd0,   1'b0, 1'b1, 5'b01010},
    '{OP_HOME,  1'b0, 8'd255, 8'd255, 1'b0, 1'b1, 5'b01010},
    '{OP_MOVE,  1'b0, 8'd255, 8'd0,   1'b0, 1'b0, 5'b00000},
    '{OP_TICK,  1'b1, 8'd0,   8'd255, 1'b0, 1'b0, 5'b00000},
    '{OP_SPARE, 1'b0, 8'd255, 8'd255, 1'b0, 1'b0, 5'b00000},
    '{OP_MOVE,  1'b0, 8'd0,   8'd255, 1'b0, 1'b0, 5'b00000},
    '{OP_HOME,  1'b1, 8'd0,   8'd0,   1'b0, 1'b0, 5'b00000},
    '{OP_TICK,  1'b0, 8'd170, 8'd85,  1'b0, 1'b0, 5'b00000},
    '{OP_TICK,  1'b1, 8'd85,  8'd170, 1'b0, 1'b0, 5'b00000},
    '{OP_MOVE,  1'b1, 8'd1,   8'd1,   1'b0, 1'b0, 5'b00000},
    '{OP_TICK,  1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 5'b01010},
    '{OP_TICK,  1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 5'b01000}
  };

  logic clk;
  logic rst;

  smlb_cmd_if cmd_bus();
  smlb_res_if res_bus();
  smlb_cfg_if cfg_bus();

  stepper_move_limit_backoff_core uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .cfg(cfg_bus),
    .res(res_bus)
  );

  motion_phase_t        eng_phase  = MP_IDLE;
  logic [STEPS_W-1:0]   eng_steps  = '0;
  logic [TIMER_W-1:0]   eng_timer  = '0;
  logic                 eng_pulse  = 1'b0;
  logic                 eng_dir    = 1'b0;
  logic                 eng_homing = 1'b0;
  logic                 eng_latch  = 1'b0;
  logic                 eng_off    = 1'b1;
  logic [TIMER_W-1:0]   half_ticks = HALF_PERIOD_RST;

  motor_levels_t levels_due [$];

  int cycle_count = 0;
  int faults = 0;
  int beats_in = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("stepper_move_limit_backoff_core_test: errors");
    $finish;
  end

  task automatic pulse_tick(input logic [TIMER_W-1:0] len, input logic backoff);
    if (eng_timer == 0) begin
      if (eng_pulse) begin
        eng_pulse = 1'b0;
        eng_timer = len;
      end else begin
        if (!backoff && eng_latch) begin
          eng_dir   = ~eng_dir;
          eng_steps = BACKOFF_STEPS;
          eng_phase = MP_REV_SETTLE;
          eng_timer = SETTLE_LEN;
          eng_pulse = 1'b0;
          return;
        end
        if (backoff || !eng_homing) begin
          if (eng_steps == 0) begin
            if (backoff) begin
              eng_latch = 1'b0;
              if (eng_homing) eng_off = 1'b1;
            end
            eng_phase = MP_IDLE;
            return;
          end
          eng_steps = eng_steps - 1;
        end
        eng_pulse = 1'b1;
        eng_timer = len;
      end
    end
    eng_timer = eng_timer - 1;
  endtask

  task automatic tick_motor(input logic [1:0] op, input logic dir, input logic [7:0] tens,
                            input logic [7:0] units, input logic hit,
                            output motor_levels_t lv);
    if (hit) eng_latch = 1'b1;
    case (eng_phase)
      MP_IDLE: begin
        if (op == OP_MOVE || op == OP_HOME) begin
          eng_off    = 1'b0;
          eng_dir    = dir;
          eng_homing = (op == OP_HOME);
          eng_steps  = (op == OP_MOVE) ? STEPS_W'((tens * 10 + units) * STEPS_PER_MM) : '0;
          eng_phase  = MP_SETTLE;
          eng_timer  = SETTLE_LEN;
          eng_pulse  = 1'b0;
        end
      end
      MP_SETTLE, MP_REV_SETTLE: begin
        if (eng_timer != 0) eng_timer = eng_timer - 1;
        if (eng_timer == 0) eng_phase = (eng_phase == MP_SETTLE) ? MP_STEP : MP_BACKOFF;
      end
      MP_STEP: pulse_tick((half_ticks == 0) ? TIMER_W'(1) : half_ticks, 1'b0);
      MP_BACKOFF: pulse_tick(BACKOFF_HALF, 1'b1);
      default: begin
        eng_phase = MP_IDLE;
        eng_pulse = 1'b0;
        eng_timer = '0;
      end
    endcase
    lv = '{eng_pulse, eng_dir, eng_off, eng_phase != MP_IDLE, eng_latch};
  endtask

  task automatic send_beat(input logic [1:0] op, input logic dir, input logic [7:0] tens,
                           input logic [7:0] units, input logic hit, input logic typed,
                           input motor_levels_t want);
    motor_levels_t lv;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.direction <= dir;
    cmd_bus.tens_mm   <= tens;
    cmd_bus.units_mm  <= units;
    cmd_bus.limit_hit <= hit;
    do @(posedge clk); while (!cmd_bus.ready);
    tick_motor(op, dir, tens, units, hit, lv);
    levels_due.push_back(typed ? want : lv);
    beats_in++;
  endtask

  task automatic send_noise(input logic hit);
    send_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), hit, 1'b0, '0);
  endtask

  task automatic write_half_period(input logic [TIMER_W-1:0] value);
    cmd_bus.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_bus.data  <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    half_ticks = value;
    cfg_writes++;
  endtask

  // Commands given while idle keep their distances short so that each move
  // finishes; commands while busy carry any field values since they are dropped.
  task automatic run_random(input int quota, input bit with_long_move, input bit with_hold);
    int counted;
    int pick;
    bit long_left;
    counted = 0;
    long_left = with_long_move;
    while (counted < quota || eng_phase != MP_IDLE) begin
      if (with_hold && counted == quota / 4 && hold_asks == hold_seen) begin
        hold_asks++;
        with_hold = 1'b0;
      end
      if (eng_steps == 0) counted++;
      if (eng_phase != MP_IDLE) begin
        send_noise(1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (long_left && counted >= quota / 2) begin
          long_left = 1'b0;
          send_beat(OP_MOVE, 1'($urandom_range(0, 1)), 8'd0, 8'd1, 1'b0, 1'b0, '0);
        end else if (pick < 35) begin
          send_beat(OP_MOVE, 1'($urandom_range(0, 1)), 8'd0, 8'd0, 1'b0, 1'b0, '0);
        end else if (pick < 45) begin
          send_beat(OP_SPARE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else begin
          send_beat(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= 300;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    motor_levels_t got;
    motor_levels_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.step_level, res_bus.dir_level, res_bus.enable_n, res_bus.busy_res,
              res_bus.limit_flag};
      if (levels_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result beat with nothing pending: step %b dir %b en_n %b busy %b limit %b",
                   got.step, got.dir, got.enable_n, got.busy, got.flag);
      end else begin
        want = levels_due.pop_front();
        results_checked++;
        if (got !== want) begin
          faults++;
          if (faults <= 10)
            $display("result %0d: want step %b dir %b en_n %b busy %b limit %b, got %b %b %b %b %b",
                     results_checked, want.step, want.dir, want.enable_n, want.busy, want.flag,
                     got.step, got.dir, got.enable_n, got.busy, got.flag);
        end
      end
    end
  end

  initial begin
    int waited;
    bit pulsed;
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = OP_TICK;
    cmd_bus.direction = 1'b0;
    cmd_bus.tens_mm = 8'd0;
    cmd_bus.units_mm = 8'd0;
    cmd_bus.limit_hit = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i])
      send_beat(opening_rows[i].op, opening_rows[i].dir, opening_rows[i].tens,
                opening_rows[i].units, opening_rows[i].hit, opening_rows[i].typed,
                opening_rows[i].want);

    write_half_period(TIMER_W'(1));
    run_random(210, 1'b0, 1'b1);

    write_half_period(TIMER_W'(0));
    send_idle_pct = 47;
    run_random(210, 1'b0, 1'b0);

    send_idle_pct = 0;
    stall_pct = 47;
    write_half_period(TIMER_W'($urandom_range(2, 3)));
    run_random(210, 1'b0, 1'b0);

    send_idle_pct = 35;
    stall_pct = 35;
    write_half_period(TIMER_W'($urandom_range(4, 500)));
    run_random(210, 1'b0, 1'b0);

    // Homing at a short half period: the limit switch trips exactly at a step
    // boundary, the direction reverses and the backoff starts while further hits
    // land on a flag that is already set.
    send_idle_pct = 0;
    stall_pct = 0;
    write_half_period(TIMER_W'(2));
    send_beat(OP_HOME, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
              1'b0, '0);
    pulsed = 1'b0;
    while (!(pulsed && eng_phase == MP_STEP && !eng_pulse && eng_timer == 0)) begin
      send_noise(1'b0);
      if (eng_pulse) pulsed = 1'b1;
    end
    send_noise(1'b1);
    repeat (80) send_noise(1'($urandom_range(0, 1)));

    cmd_bus.valid <= 1'b0;
    waited = 0;
    while (levels_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (levels_due.size() != 0) begin
      faults += levels_due.size();
      $display("%0d expected result beats never arrived", levels_due.size());
    end

    $display("Ran %0d command beats and checked %0d result beats over %0d half period settings,",
             beats_in, results_checked, cfg_writes + 1);
    $display("with zero distance moves, dropped commands, a long result stall and a homing run "
             + "that trips the limit and starts its backoff.");
    if (faults == 0) begin
      $display("stepper_move_limit_backoff_core_test: clean");
    end else begin
      $display("stepper_move_limit_backoff_core_test: errors");
    end
    $finish;
  end

endmodule
